@@ rtl/core/gsp_pkg.sv @@
// Shared types and constants for the braced GUID text parser.
// Used by the front stage, the queue, the back stage and the top level.
// No dependencies.
package gsp_pkg;

   localparam int unsigned CU_W    = 16;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [CU_W-1:0] CHAR_LBRACE = 16'h007B;
   localparam logic [CU_W-1:0] CHAR_RBRACE = 16'h007D;
   localparam logic [CU_W-1:0] CHAR_DASH   = 16'h002D;
   localparam logic [CU_W-1:0] CHAR_NUL    = 16'h0000;

   localparam logic [POS_W-1:0] TEXT_LEN  = 6'd38;
   localparam logic [POS_W-1:0] POS_LAST  = 6'd37;
   localparam logic [POS_W-1:0] POS_MAX   = 6'd63;
   localparam logic [POS_W-1:0] POS_DASH1 = 6'd9;
   localparam logic [POS_W-1:0] POS_DASH2 = 6'd14;
   localparam logic [POS_W-1:0] POS_DASH3 = 6'd19;
   localparam logic [POS_W-1:0] POS_DASH4 = 6'd24;

   typedef enum logic [1:0] {
      OP_UNIT,
      OP_TERM,
      OP_ABSENT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_lbrace;
      logic       is_rbrace;
      logic       is_dash;
   } item_type;

endpackage

@@ rtl/core/gsp_front.sv @@
// Front stage: accepts request transactions and classifies each code unit.
// Depends on gsp_pkg.
module gsp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [gsp_pkg::CU_W-1:0] req_code_unit,
   input  logic                     req_absent_string,
   output logic                     item_valid,
   input  logic                     item_ready,
   output gsp_pkg::item_type        item
);

   logic              valid_ff;
   logic              valid_in;
   gsp_pkg::item_type item_ff;
   gsp_pkg::item_type item_in;
   logic              is_digit;
   logic              is_lower;
   logic              is_upper;

   assign req_ready  = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      is_digit = (req_code_unit >= 16'h0030) && (req_code_unit <= 16'h0039);
      is_lower = (req_code_unit >= 16'h0061) && (req_code_unit <= 16'h0066);
      is_upper = (req_code_unit >= 16'h0041) && (req_code_unit <= 16'h0046);

      if (req_absent_string) begin
         item_in.op = gsp_pkg::OP_ABSENT;
      end else if (req_code_unit == gsp_pkg::CHAR_NUL) begin
         item_in.op = gsp_pkg::OP_TERM;
      end else begin
         item_in.op = gsp_pkg::OP_UNIT;
      end
      item_in.is_hex    = is_digit || is_lower || is_upper;
      item_in.hex_val   = is_digit ? req_code_unit[3:0] : req_code_unit[3:0] + 4'd9;
      item_in.is_lbrace = (req_code_unit == gsp_pkg::CHAR_LBRACE);
      item_in.is_rbrace = (req_code_unit == gsp_pkg::CHAR_RBRACE);
      item_in.is_dash   = (req_code_unit == gsp_pkg::CHAR_DASH);

      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ rtl/core/gsp_queue.sv @@
// Short queue of classified items between the front and back stages.
// Depends on gsp_pkg.
module gsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gsp_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output gsp_pkg::item_type out_item
);

   gsp_pkg::item_type            entry_ff [gsp_pkg::Q_DEPTH];
   logic [gsp_pkg::Q_PTR_W-1:0]  wr_ptr_ff;
   logic [gsp_pkg::Q_PTR_W-1:0]  wr_ptr_in;
   logic [gsp_pkg::Q_PTR_W-1:0]  rd_ptr_ff;
   logic [gsp_pkg::Q_PTR_W-1:0]  rd_ptr_in;
   logic [gsp_pkg::Q_CNT_W-1:0]  count_ff;
   logic [gsp_pkg::Q_CNT_W-1:0]  count_in;
   logic                         push;
   logic                         pop;

   localparam logic [gsp_pkg::Q_CNT_W-1:0] FULL    = gsp_pkg::Q_CNT_W'(gsp_pkg::Q_DEPTH);
   localparam logic [gsp_pkg::Q_PTR_W-1:0] PTR_TOP =
      gsp_pkg::Q_PTR_W'(gsp_pkg::Q_DEPTH - 1);

   assign in_ready  = (count_ff != FULL);
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_TOP) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_TOP) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

@@ rtl/core/gsp_back.sv @@
// Back stage: checks layout position, accumulates hex digits, registers results.
// Depends on gsp_pkg.
module gsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  gsp_pkg::item_type item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_status,
   output logic [31:0]       rsp_data1,
   output logic [15:0]       rsp_data2,
   output logic [15:0]       rsp_data3,
   output logic [63:0]       rsp_data4
);

   logic [gsp_pkg::POS_W-1:0] position_ff;
   logic [gsp_pkg::POS_W-1:0] position_in;
   logic                      bad_ff;
   logic                      bad_in;
   logic [63:0]               acc_high_ff;
   logic [63:0]               acc_high_in;
   logic [63:0]               acc_low_ff;
   logic [63:0]               acc_low_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      status_ff;
   logic                      status_in;
   logic [127:0]              guid_ff;
   logic [127:0]              guid_in;
   logic                      slot_free;
   logic                      take;
   logic                      emit;
   logic                      dash_pos;
   logic                      ok;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign item_ready = (item.op == gsp_pkg::OP_UNIT) || slot_free;
   assign take       = item_valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_data1  = guid_ff[127:96];
   assign rsp_data2  = guid_ff[95:80];
   assign rsp_data3  = guid_ff[79:64];
   assign rsp_data4  = guid_ff[63:0];

   always_comb begin
      position_in  = position_ff;
      bad_in       = bad_ff;
      acc_high_in  = acc_high_ff;
      acc_low_in   = acc_low_ff;
      emit         = 1'b0;
      status_in    = 1'b0;
      guid_in      = '0;
      dash_pos     = (position_ff == gsp_pkg::POS_DASH1) || (position_ff == gsp_pkg::POS_DASH2)
                  || (position_ff == gsp_pkg::POS_DASH3) || (position_ff == gsp_pkg::POS_DASH4);
      ok           = !bad_ff && (position_ff == gsp_pkg::TEXT_LEN);

      if (take) begin
         unique case (item.op)
            gsp_pkg::OP_UNIT: begin
               if (position_ff >= gsp_pkg::TEXT_LEN) begin
                  bad_in = 1'b1;
               end else if (position_ff == '0) begin
                  if (!item.is_lbrace) bad_in = 1'b1;
               end else if (position_ff == gsp_pkg::POS_LAST) begin
                  if (!item.is_rbrace) bad_in = 1'b1;
               end else if (dash_pos) begin
                  if (!item.is_dash) bad_in = 1'b1;
               end else if (item.is_hex) begin
                  acc_high_in = {acc_high_ff[59:0], acc_low_ff[63:60]};
                  acc_low_in  = {acc_low_ff[59:0], item.hex_val};
               end else begin
                  bad_in = 1'b1;
               end
               if (position_ff != gsp_pkg::POS_MAX) begin
                  position_in = position_ff + 1'b1;
               end
            end
            gsp_pkg::OP_TERM: begin
               emit      = 1'b1;
               status_in = !ok;
               guid_in   = ok ? {acc_high_ff, acc_low_ff} : '0;
            end
            gsp_pkg::OP_ABSENT: begin
               emit = 1'b1;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
         if (emit) begin
            position_in = '0;
            bad_in      = 1'b0;
            acc_high_in = '0;
            acc_low_in  = '0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (slot_free) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         bad_ff       <= 1'b0;
         acc_high_ff  <= '0;
         acc_low_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         bad_ff       <= bad_in;
         acc_high_ff  <= acc_high_in;
         acc_low_ff   <= acc_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff <= status_in;
         guid_ff   <= guid_in;
      end
   end

endmodule

@@ rtl/core/guid_string_parser.sv @@
// Braced GUID text parser, top level. Takes one UTF-16 code unit per transaction,
// checks the layout {8-4-4-4-12} with hex digits of either case, and on the zero
// terminator (or an absent-string transaction) returns status and the GUID fields.
// Sustains one code unit per clock cycle while no terminator is stalled at the back
// stage; a result passes the front register, a queue entry and the back result
// register before rsp_valid rises. A terminator or absent-string transaction waits
// at the back stage while an earlier result is still held at the output. The rate
// is set by the back stage, which updates position and the 128-bit accumulator for
// each code unit. Depends on gsp_pkg, gsp_front, gsp_queue, gsp_back.
module guid_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_absent_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [31:0] rsp_data1,
   output logic [15:0] rsp_data2,
   output logic [15:0] rsp_data3,
   output logic [63:0] rsp_data4
);

   logic              front_valid;
   logic              front_ready;
   gsp_pkg::item_type front_item;
   logic              back_valid;
   logic              back_ready;
   gsp_pkg::item_type back_item;

   gsp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_code_unit     (req_code_unit),
      .req_absent_string (req_absent_string),
      .item_valid        (front_valid),
      .item_ready        (front_ready),
      .item              (front_item)
   );

   gsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_item  (back_item)
   );

   gsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data1  (rsp_data1),
      .rsp_data2  (rsp_data2),
      .rsp_data3  (rsp_data3),
      .rsp_data4  (rsp_data4)
   );

endmodule
